/* rtl/core/tlvhp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvhp_pkg: shared types and codes for the TLV header stream parser
// Parse phases, byte roles, error codes and the state and result records.
// ----------------------------------------------------------------------------
package tlvhp_pkg;

    localparam logic [7:0] MARK_TWO  = 8'd253;
    localparam logic [7:0] MARK_FOUR = 8'd254;

    localparam logic [2:0] EXT_TWO  = 3'd2;
    localparam logic [2:0] EXT_FOUR = 3'd4;

    typedef enum logic [4:0] {
        PH_TYPE     = 5'b00001,
        PH_TYPE_EXT = 5'b00010,
        PH_LEN      = 5'b00100,
        PH_LEN_EXT  = 5'b01000,
        PH_VALUE    = 5'b10000
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_TYPE    = 2'd0,
        ROLE_LEN     = 2'd1,
        ROLE_VALUE   = 2'd2,
        ROLE_DISCARD = 2'd3
    } t_role;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_MARKER     = 2'd1,
        ERR_END_HEADER = 2'd2,
        ERR_END_VALUE  = 2'd3
    } t_err;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  ext_left;
        logic [31:0] acc;
        logic [31:0] held_type;
        logic [31:0] held_len;
        logic [31:0] val_rem;
        logic        failed;
    } t_state;

    typedef struct packed {
        t_role       role;
        logic        header_done;
        logic [31:0] etype;
        logic [31:0] elen;
        logic        value_end;
        t_err        err;
        logic        ok;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:     PH_TYPE,
        ext_left:  3'd0,
        acc:       32'd0,
        held_type: 32'd0,
        held_len:  32'd0,
        val_rem:   32'd0,
        failed:    1'b0
    };

endpackage

/* rtl/core/tlvhp_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvhp_step: per-byte parse step
// Forms the next parser state and the result record for one packet byte.
// ----------------------------------------------------------------------------
module tlvhp_step (
    input  tlvhp_pkg::t_state  i_state,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output tlvhp_pkg::t_state  o_state,
    output tlvhp_pkg::t_result o_result
);
    import tlvhp_pkg::*;

    t_state      n_state;
    t_result     n_result;
    logic        is_type;
    logic        len_done;
    logic [31:0] len_val;
    logic [2:0]  ext_dec;
    logic [31:0] acc_next;
    logic [31:0] rem_dec;

    always_comb begin
        n_state  = i_state;
        n_result = '0;
        len_done = 1'b0;
        len_val  = 32'd0;
        is_type  = (i_state.phase == PH_TYPE) || (i_state.phase == PH_TYPE_EXT);
        ext_dec  = (i_state.ext_left != 3'd0) ? i_state.ext_left - 3'd1 : 3'd0;
        acc_next = {i_state.acc[23:0], i_data_byte};
        rem_dec  = (i_state.val_rem != 32'd0) ? i_state.val_rem - 32'd1 : 32'd0;

        if (i_state.failed) begin
            n_result.role = ROLE_DISCARD;
        end else begin
            case (i_state.phase)
                PH_TYPE, PH_LEN: begin
                    n_result.role = is_type ? ROLE_TYPE : ROLE_LEN;
                    if (i_data_byte < MARK_TWO) begin
                        if (is_type) begin
                            n_state.held_type = {24'd0, i_data_byte};
                            n_state.phase     = PH_LEN;
                        end else begin
                            len_done = 1'b1;
                            len_val  = {24'd0, i_data_byte};
                        end
                    end else if (i_data_byte == MARK_TWO || i_data_byte == MARK_FOUR) begin
                        n_state.ext_left = (i_data_byte == MARK_TWO) ? EXT_TWO : EXT_FOUR;
                        n_state.acc      = 32'd0;
                        n_state.phase    = is_type ? PH_TYPE_EXT : PH_LEN_EXT;
                    end else begin
                        n_result.err   = ERR_MARKER;
                        n_state.failed = 1'b1;
                    end
                end
                PH_TYPE_EXT, PH_LEN_EXT: begin
                    n_result.role    = is_type ? ROLE_TYPE : ROLE_LEN;
                    n_state.acc      = acc_next;
                    n_state.ext_left = ext_dec;
                    if (ext_dec == 3'd0) begin
                        if (is_type) begin
                            n_state.held_type = acc_next;
                            n_state.phase     = PH_LEN;
                        end else begin
                            len_done = 1'b1;
                            len_val  = acc_next;
                        end
                    end
                end
                PH_VALUE: begin
                    n_result.role   = ROLE_VALUE;
                    n_result.etype  = i_state.held_type;
                    n_result.elen   = i_state.held_len;
                    n_state.val_rem = rem_dec;
                    if (rem_dec == 32'd0) begin
                        n_result.value_end = 1'b1;
                        n_state.phase      = PH_TYPE;
                    end
                end
                default: begin
                    n_state = STATE_RESET;
                end
            endcase
        end

        // header complete: report it, then end the element or enter its value
        if (len_done) begin
            n_state.held_len     = len_val;
            n_result.header_done = 1'b1;
            n_result.etype       = i_state.held_type;
            n_result.elen        = len_val;
            if (len_val == 32'd0) begin
                n_result.value_end = 1'b1;
                n_state.phase      = PH_TYPE;
            end else begin
                n_state.val_rem = len_val;
                n_state.phase   = PH_VALUE;
            end
        end

        if (i_last_byte) begin
            if (!i_state.failed && !n_state.failed) begin
                if (n_state.phase == PH_TYPE) begin
                    n_result.ok = 1'b1;
                end else if (n_state.phase == PH_VALUE) begin
                    n_result.err = ERR_END_VALUE;
                end else begin
                    n_result.err = ERR_END_HEADER;
                end
            end
            n_state = STATE_RESET;
        end
    end

    assign o_state  = n_state;
    assign o_result = n_result;

endmodule

/* rtl/core/tlv_header_stream_parser_core.sv */
`timescale 1ns / 1ps
// Each byte passes through the input register and then the result register before its result appears.
// One byte per cycle is sustained while the output is not stalled; the per-byte state update in tlvhp_step
// closes the only loop and is combinational.
// Reset: synchronous, active low; clears the parser state and both valid flags,
// leaving the parser expecting the first type byte of a packet.
// ----------------------------------------------------------------------------
// tlv_header_stream_parser_core: streaming TLV header parser
// Input register, per-byte parse step and result register with valid/ready.
// ----------------------------------------------------------------------------
module tlv_header_stream_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_byte_role,
    output logic        o_header_done,
    output logic [31:0] o_element_type,
    output logic [31:0] o_element_length,
    output logic        o_value_end,
    output logic [1:0]  o_error_code,
    output logic        o_packet_ok
);
    import tlvhp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_out;
    logic       r_out_valid;
    logic       adv;

    // advance the held byte when the result register is free or being drained
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    tlvhp_step u_step (
        .i_state     (r_state),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (adv) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_byte_role      = r_out.role;
    assign o_header_done    = r_out.header_done;
    assign o_element_type   = r_out.etype;
    assign o_element_length = r_out.elen;
    assign o_value_end      = r_out.value_end;
    assign o_error_code     = r_out.err;
    assign o_packet_ok      = r_out.ok;

    // a header completes only on a length byte
    a_header_on_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_header_done |-> o_byte_role == ROLE_LEN)
        else $error("header_done on a byte that is not a length byte");

    // a clean packet end carries no error
    a_ok_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_packet_ok |-> o_error_code == ERR_NONE)
        else $error("packet_ok raised together with an error code");

    // discarded bytes report nothing else
    a_discard_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_role == ROLE_DISCARD |->
            !o_header_done && !o_value_end && !o_packet_ok &&
            o_error_code == ERR_NONE && o_element_type == 32'd0 &&
            o_element_length == 32'd0)
        else $error("discarded byte reports a field");

    // the parser is back at its reset state after the last byte of a packet
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in_last |=> r_state.phase == PH_TYPE && !r_state.failed)
        else $error("state not cleared at packet end");

endmodule

/* dv/tlv_header_stream_parser_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_header_stream_parser_core_test: self-checking bench for the TLV parser
// Walks a directed table of packets that covers the number extremes, the 255
// marker and every packet-end error, then streams random packets. Most are
// well formed, the rest are truncated, corrupted or pure noise. Results are
// predicted per byte and checked field by field. Both sides stall at random,
// and one long output stall backs the parser up onto its input.
// ----------------------------------------------------------------------------
module tlv_header_stream_parser_core_test;
    import tlvhp_pkg::*;

    localparam int RANDOM_BYTES = 950;
    localparam int CALM_AFTER   = 800;
    localparam int LONG_HOLD    = 40;
    localparam int ROWS         = 25;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_result    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_byte_role;
    logic        o_header_done;
    logic [31:0] o_element_type;
    logic [31:0] o_element_length;
    logic        o_value_end;
    logic [1:0]  o_error_code;
    logic        o_packet_ok;

    // Parser model state
    t_phase      pm_phase;
    logic [2:0]  pm_ext_left;
    logic [31:0] pm_acc;
    logic [31:0] pm_type;
    logic [31:0] pm_len;
    logic [31:0] pm_remaining;
    logic        pm_failed;

    t_result     pending_results [$];
    logic [7:0]  packet_bytes [$];
    t_row        stim_table [0:ROWS-1];
    int          n_sent;
    int          n_results;
    int          n_errors;

    tlv_header_stream_parser_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_byte_role      (o_byte_role),
        .o_header_done    (o_header_done),
        .o_element_type   (o_element_type),
        .o_element_length (o_element_length),
        .o_value_end      (o_value_end),
        .o_error_code     (o_error_code),
        .o_packet_ok      (o_packet_ok)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void clear_parser();
        pm_phase     = PH_TYPE;
        pm_ext_left  = 3'd0;
        pm_acc       = 32'd0;
        pm_type      = 32'd0;
        pm_len       = 32'd0;
        pm_remaining = 32'd0;
        pm_failed    = 1'b0;
    endfunction

    function automatic t_result res(t_role role, logic hd, logic [31:0] etype,
                                    logic [31:0] elen, logic vend, t_err err, logic ok);
        t_result r;
        r.role        = role;
        r.header_done = hd;
        r.etype       = etype;
        r.elen        = elen;
        r.value_end   = vend;
        r.err         = err;
        r.ok          = ok;
        return r;
    endfunction

    // Length number complete: report the header and end the element or enter its value
    function automatic void close_header(input logic [31:0] len, inout t_result r);
        pm_len        = len;
        r.header_done = 1'b1;
        r.etype       = pm_type;
        r.elen        = len;
        if (len == 32'd0) begin
            r.value_end = 1'b1;
            pm_phase    = PH_TYPE;
        end else begin
            pm_remaining = len;
            pm_phase     = PH_VALUE;
        end
    endfunction

    function automatic t_result parse_byte(input logic [7:0] b, input logic last);
        t_result r;
        logic    was_failed;
        logic    in_type;
        r          = '0;
        was_failed = pm_failed;
        in_type    = (pm_phase == PH_TYPE) || (pm_phase == PH_TYPE_EXT);
        if (pm_failed) begin
            r.role = ROLE_DISCARD;
        end else if (pm_phase == PH_TYPE || pm_phase == PH_LEN) begin
            r.role = in_type ? ROLE_TYPE : ROLE_LEN;
            if (b < MARK_TWO) begin
                if (in_type) begin
                    pm_type  = {24'd0, b};
                    pm_phase = PH_LEN;
                end else begin
                    close_header({24'd0, b}, r);
                end
            end else if (b == MARK_TWO || b == MARK_FOUR) begin
                pm_ext_left = (b == MARK_TWO) ? EXT_TWO : EXT_FOUR;
                pm_acc      = 32'd0;
                pm_phase    = in_type ? PH_TYPE_EXT : PH_LEN_EXT;
            end else begin
                r.err     = ERR_MARKER;
                pm_failed = 1'b1;
            end
        end else if (pm_phase == PH_TYPE_EXT || pm_phase == PH_LEN_EXT) begin
            r.role = in_type ? ROLE_TYPE : ROLE_LEN;
            pm_acc = {pm_acc[23:0], b};
            if (pm_ext_left != 3'd0)
                pm_ext_left = pm_ext_left - 3'd1;
            if (pm_ext_left == 3'd0) begin
                if (in_type) begin
                    pm_type  = pm_acc;
                    pm_phase = PH_LEN;
                end else begin
                    close_header(pm_acc, r);
                end
            end
        end else begin
            r.role  = ROLE_VALUE;
            r.etype = pm_type;
            r.elen  = pm_len;
            if (pm_remaining != 32'd0)
                pm_remaining = pm_remaining - 32'd1;
            if (pm_remaining == 32'd0) begin
                r.value_end = 1'b1;
                pm_phase    = PH_TYPE;
            end
        end
        if (last) begin
            if (!was_failed && !pm_failed) begin
                if (pm_phase == PH_TYPE)
                    r.ok = 1'b1;
                else if (pm_phase == PH_VALUE)
                    r.err = ERR_END_VALUE;
                else
                    r.err = ERR_END_HEADER;
            end
            clear_parser();
        end
        return r;
    endfunction

    // Append a number, sometimes in a longer form than it needs
    function automatic void push_number(input logic [31:0] v);
        if (v < 32'd253 && $urandom_range(0, 3) != 0) begin
            packet_bytes.push_back(v[7:0]);
        end else if (v < 32'h1_0000 && $urandom_range(0, 1) == 0) begin
            packet_bytes.push_back(MARK_TWO);
            packet_bytes.push_back(v[15:8]);
            packet_bytes.push_back(v[7:0]);
        end else begin
            packet_bytes.push_back(MARK_FOUR);
            packet_bytes.push_back(v[31:24]);
            packet_bytes.push_back(v[23:16]);
            packet_bytes.push_back(v[15:8]);
            packet_bytes.push_back(v[7:0]);
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("result %0d: %s got 0x%0h, expected 0x%0h",
                                    n_results, name, got, want));
    endtask

    task automatic check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch($sformatf("result %0d arrived with none pending", n_results));
        end else begin
            want = pending_results.pop_front();
            compare_field("byte_role", {30'd0, o_byte_role}, {30'd0, want.role});
            compare_field("header_done", {31'd0, o_header_done}, {31'd0, want.header_done});
            compare_field("element_type", o_element_type, want.etype);
            compare_field("element_length", o_element_length, want.elen);
            compare_field("value_end", {31'd0, o_value_end}, {31'd0, want.value_end});
            compare_field("error_code", {30'd0, o_error_code}, {30'd0, want.err});
            compare_field("packet_ok", {31'd0, o_packet_ok}, {31'd0, want.ok});
        end
        n_results++;
    endtask

    // Offer one byte, hold it until taken, then log what it must produce
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input t_result want);
        t_result predicted;
        if (n_sent < CALM_AFTER && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predicted = parse_byte(b, last);
        pending_results.push_back(typed ? want : predicted);
        n_sent++;
    endtask

    // Output side: random stalls plus one long hold-off to back the parser up
    initial begin
        int hold_left;
        bit long_hold_done;
        hold_left      = 0;
        long_hold_done = 1'b0;
        i_out_ready   <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready === 1'b1)
                check_result();
            if (!long_hold_done && n_results >= 300) begin
                hold_left      = LONG_HOLD;
                long_hold_done = 1'b1;
            end else if (hold_left == 0 && n_sent < CALM_AFTER && $urandom_range(0, 4) == 0) begin
                hold_left = $urandom_range(1, 3);
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int          kind;
        int          nelem;
        int          cut;
        logic [31:0] tval;
        logic [31:0] lval;
        n_sent       = 0;
        n_results    = 0;
        n_errors     = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'd0;
        i_last_byte <= 1'b0;
        clear_parser();

        // zero-length element, then a lone 255 marker
        stim_table[0]  = '{8'h05, 1'b0, 1'b1,
                           res(ROLE_TYPE, 1'b0, 32'd0, 32'd0, 1'b0, ERR_NONE, 1'b0)};
        stim_table[1]  = '{8'h00, 1'b1, 1'b1,
                           res(ROLE_LEN, 1'b1, 32'd5, 32'd0, 1'b1, ERR_NONE, 1'b1)};
        stim_table[2]  = '{8'hFF, 1'b1, 1'b1,
                           res(ROLE_TYPE, 1'b0, 32'd0, 32'd0, 1'b0, ERR_MARKER, 1'b0)};
        // largest type in four bytes, length 2 in a non-minimal two-byte form
        stim_table[3]  = '{8'hFE, 1'b0, 1'b0, '0};
        stim_table[4]  = '{8'hFF, 1'b0, 1'b0, '0};
        stim_table[5]  = '{8'hFF, 1'b0, 1'b0, '0};
        stim_table[6]  = '{8'hFF, 1'b0, 1'b0, '0};
        stim_table[7]  = '{8'hFF, 1'b0, 1'b0, '0};
        stim_table[8]  = '{8'hFD, 1'b0, 1'b0, '0};
        stim_table[9]  = '{8'h00, 1'b0, 1'b0, '0};
        stim_table[10] = '{8'h02, 1'b0, 1'b1,
                           res(ROLE_LEN, 1'b1, 32'hFFFF_FFFF, 32'd2, 1'b0, ERR_NONE, 1'b0)};
        stim_table[11] = '{8'hAA, 1'b0, 1'b0, '0};
        stim_table[12] = '{8'hBB, 1'b1, 1'b1,
                           res(ROLE_VALUE, 1'b0, 32'hFFFF_FFFF, 32'd2, 1'b1, ERR_NONE, 1'b1)};
        // marker in the length, then discarded bytes up to packet end
        stim_table[13] = '{8'hFC, 1'b0, 1'b1,
                           res(ROLE_TYPE, 1'b0, 32'd0, 32'd0, 1'b0, ERR_NONE, 1'b0)};
        stim_table[14] = '{8'hFF, 1'b0, 1'b1,
                           res(ROLE_LEN, 1'b0, 32'd0, 32'd0, 1'b0, ERR_MARKER, 1'b0)};
        stim_table[15] = '{8'h11, 1'b0, 1'b1,
                           res(ROLE_DISCARD, 1'b0, 32'd0, 32'd0, 1'b0, ERR_NONE, 1'b0)};
        stim_table[16] = '{8'h22, 1'b1, 1'b1,
                           res(ROLE_DISCARD, 1'b0, 32'd0, 32'd0, 1'b0, ERR_NONE, 1'b0)};
        // largest length, packet ends inside the value
        stim_table[17] = '{8'h00, 1'b0, 1'b0, '0};
        stim_table[18] = '{8'hFE, 1'b0, 1'b0, '0};
        stim_table[19] = '{8'hFF, 1'b0, 1'b0, '0};
        stim_table[20] = '{8'hFF, 1'b0, 1'b0, '0};
        stim_table[21] = '{8'hFF, 1'b0, 1'b0, '0};
        stim_table[22] = '{8'hFF, 1'b1, 1'b1,
                           res(ROLE_LEN, 1'b1, 32'd0, 32'hFFFF_FFFF, 1'b0, ERR_END_VALUE, 1'b0)};
        // packet ends inside an extended type
        stim_table[23] = '{8'hFD, 1'b0, 1'b1,
                           res(ROLE_TYPE, 1'b0, 32'd0, 32'd0, 1'b0, ERR_NONE, 1'b0)};
        stim_table[24] = '{8'h12, 1'b1, 1'b1,
                           res(ROLE_TYPE, 1'b0, 32'd0, 32'd0, 1'b0, ERR_END_HEADER, 1'b0)};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < ROWS; r++)
            send_byte(stim_table[r].data, stim_table[r].last, stim_table[r].typed,
                      stim_table[r].want);

        while (n_sent < ROWS + RANDOM_BYTES) begin
            packet_bytes.delete();
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                repeat ($urandom_range(1, 6)) packet_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                nelem = $urandom_range(1, 4);
                repeat (nelem) begin
                    case ($urandom_range(0, 2))
                        0: tval = $urandom_range(0, 252);
                        1: tval = $urandom_range(0, 65535);
                        default: tval = $urandom;
                    endcase
                    push_number(tval);
                    if ($urandom_range(0, 29) == 0) begin
                        // huge length: the packet will end inside the value
                        lval = $urandom | 32'h0001_0000;
                        push_number(lval);
                        repeat ($urandom_range(0, 4))
                            packet_bytes.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        lval = $urandom_range(0, 8);
                        push_number(lval);
                        repeat (lval) packet_bytes.push_back(8'($urandom_range(0, 255)));
                    end
                end
                if (kind < 20 && packet_bytes.size() > 1) begin
                    cut = $urandom_range(1, packet_bytes.size() - 1);
                    repeat (cut) void'(packet_bytes.pop_back());
                end else if (kind < 26) begin
                    packet_bytes[$urandom_range(0, packet_bytes.size() - 1)] = 8'hFF;
                end
            end
            for (int k = 0; k < packet_bytes.size(); k++)
                send_byte(packet_bytes[k], k == packet_bytes.size() - 1, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("ERROR: run did not finish in time");
        $display("Test completed with failures");
        $finish;
    end

endmodule
